>>> design/scdconv_pkg.sv
// ----------------------------------------------------------------------------
// scdconv_pkg
// Shared types and constants for the segmented causal depthwise convolution.
// ----------------------------------------------------------------------------
`default_nettype none

package scdconv_pkg;

  // Default sizes of the block
  localparam int unsigned ChannelsDef = 64;
  localparam int unsigned TapsDef     = 4;

  // Fixed field widths
  localparam int unsigned ChW  = 6;
  localparam int unsigned TapW = 2;
  localparam int unsigned ValW = 16;
  localparam int unsigned SegW = 8;
  localparam int unsigned OpW  = 2;

  // Product of a Q8.8 sample and a Q1.15 weight
  localparam int unsigned ProdW = 2 * ValW;
  // Fraction bits dropped from the exact sum
  localparam int unsigned FracShift = 15;

  typedef enum logic [OpW-1:0] {
    OP_WEIGHT = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [ChW-1:0]         channel;
    logic [TapW-1:0]        tap;
    logic signed [ValW-1:0] value;
    logic [SegW-1:0]        segment;
  } in_item_t;

  typedef struct packed {
    logic [ChW-1:0]         out_channel;
    logic signed [ValW-1:0] out_value;
    logic                   saturated;
  } out_item_t;

endpackage

`default_nettype wire

>>> design/scdconv_wmem.sv
// ----------------------------------------------------------------------------
// scdconv_wmem
// Weight memory: one row of TAPS weights per channel, written one tap at a
// time, read one row per cycle. Entries never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module scdconv_wmem
  import scdconv_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef,
  parameter int unsigned TAPS     = TapsDef,
  localparam int unsigned AddrW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned LaneW   = $clog2(TAPS)
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              wr_en_i,
  input  wire logic [AddrW-1:0]                  wr_ch_i,
  input  wire logic [LaneW-1:0]                  wr_tap_i,
  input  wire logic [ValW-1:0]                   wr_data_i,
  input  wire logic                              rd_en_i,
  input  wire logic [AddrW-1:0]                  rd_ch_i,
  output logic      [TAPS-1:0][ValW-1:0]         rd_row_o
);

  logic [TAPS-1:0][ValW-1:0] mem [CHANNELS];
  logic [CHANNELS-1:0][TAPS-1:0] wvalid_q;
  logic [TAPS-1:0][ValW-1:0] rd_q;
  logic [TAPS-1:0]           rv_q;

  // Write one tap lane, read one row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ch_i][wr_tap_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_ch_i];
    end
  end

  // Track written entries; capture their flags with the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q <= '0;
      rv_q     <= '0;
    end else begin
      if (wr_en_i) begin
        wvalid_q[wr_ch_i][wr_tap_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rv_q <= wvalid_q[rd_ch_i];
      end
    end
  end

  // Zero unwritten lanes
  always_comb begin
    for (int t = 0; t < TAPS; t++) begin
      rd_row_o[t] = rv_q[t] ? rd_q[t] : '0;
    end
  end

endmodule

`default_nettype wire

>>> design/scdconv_hist.sv
// ----------------------------------------------------------------------------
// scdconv_hist
// History memory: per channel the last TAPS-1 samples, their segment ids and
// a fill count. Read at accept, shifted and written back when the item
// leaves the first stage, with forwarding for back-to-back use of a channel.
// ----------------------------------------------------------------------------
`default_nettype none

module scdconv_hist
  import scdconv_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef,
  parameter int unsigned TAPS     = TapsDef,
  localparam int unsigned AddrW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int unsigned Hist    = TAPS - 1,
  localparam int unsigned FillW   = $clog2(TAPS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clr_i,
  input  wire logic                         rd_en_i,
  input  wire logic [AddrW-1:0]             rd_ch_i,
  input  wire logic                         wr_en_i,
  input  wire logic [AddrW-1:0]             wr_ch_i,
  input  wire logic [ValW-1:0]              wr_smp_i,
  input  wire logic [SegW-1:0]              wr_seg_i,
  output logic      [FillW-1:0]             fill_o,
  output logic      [Hist-1:0][SegW-1:0]    seg_o,
  output logic      [Hist-1:0][ValW-1:0]    smp_o
);

  typedef struct packed {
    logic [FillW-1:0]          fill;
    logic [Hist-1:0][SegW-1:0] seg;
    logic [Hist-1:0][ValW-1:0] smp;
  } hrow_t;

  hrow_t mem [CHANNELS];
  logic [CHANNELS-1:0] hvalid_q;
  hrow_t rd_q;
  hrow_t fwd_row_q;
  logic  fwd_q;
  logic  rv_q;
  hrow_t cur;
  hrow_t new_row;
  logic  same_ch;

  assign same_ch = wr_en_i && (wr_ch_i == rd_ch_i);

  // Select the freshest copy of the row; a channel not written since reset or clear has no past rows
  always_comb begin
    cur = fwd_q ? fwd_row_q : rd_q;
    if (!rv_q) begin
      cur.fill = '0;
    end
  end

  assign fill_o = cur.fill;
  assign seg_o  = cur.seg;
  assign smp_o  = cur.smp;

  // Shift the current sample in and advance the fill count
  always_comb begin
    new_row        = cur;
    new_row.smp[0] = wr_smp_i;
    new_row.seg[0] = wr_seg_i;
    for (int d = 1; d < Hist; d++) begin
      new_row.smp[d] = cur.smp[d-1];
      new_row.seg[d] = cur.seg[d-1];
    end
    if (cur.fill < FillW'(Hist)) begin
      new_row.fill = cur.fill + 1'b1;
    end
  end

  // Memory port and forwarding row
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_ch_i] <= new_row;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_ch_i];
      fwd_row_q <= new_row;
    end
  end

  // Row flags: clear wins over a write at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hvalid_q <= '0;
      fwd_q    <= 1'b0;
      rv_q     <= 1'b0;
    end else begin
      if (clr_i) begin
        hvalid_q <= '0;
      end else if (wr_en_i) begin
        hvalid_q[wr_ch_i] <= 1'b1;
      end
      if (rd_en_i) begin
        fwd_q <= same_ch;
        rv_q  <= hvalid_q[rd_ch_i] || same_ch;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/scdconv_mac.sv
// ----------------------------------------------------------------------------
// scdconv_mac
// Filter datapath: masked tap products, then sum, floor shift and saturate
// into the output register. Two stages with their own flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module scdconv_mac
  import scdconv_pkg::*;
#(
  parameter int unsigned TAPS   = TapsDef,
  localparam int unsigned Hist  = TAPS - 1,
  localparam int unsigned FillW = $clog2(TAPS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [ChW-1:0]               ch_i,
  input  wire logic [ValW-1:0]              val_i,
  input  wire logic [SegW-1:0]              seg_i,
  input  wire logic [TAPS-1:0][ValW-1:0]    w_i,
  input  wire logic [FillW-1:0]             fill_i,
  input  wire logic [Hist-1:0][SegW-1:0]    hseg_i,
  input  wire logic [Hist-1:0][ValW-1:0]    hsmp_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output out_item_t                         out_data_o
);

  localparam int unsigned SumW  = ProdW + $clog2(TAPS);
  localparam int unsigned QW    = SumW - FracShift;

  logic signed [ProdW-1:0] prod_d [TAPS];
  logic signed [ProdW-1:0] prod_q [TAPS];
  logic [ChW-1:0]          s2_ch_q;
  logic                    s2_valid_q;
  logic                    out_valid_q;
  out_item_t               out_q;
  out_item_t               out_d;
  logic                    s2_adv;
  logic                    out_adv;
  logic signed [SumW-1:0]  acc;
  logic signed [QW-1:0]    q;
  logic                    fits;

  assign out_adv    = !out_valid_q || !out_stall_i;
  assign s2_adv     = !s2_valid_q || out_adv;
  assign in_ready_o = s2_adv;

  // Form products; drop missing rows and rows of another segment
  always_comb begin
    prod_d[TAPS-1] = $signed(val_i) * $signed(w_i[TAPS-1]);
    for (int d = 1; d <= Hist; d++) begin
      if ((fill_i >= FillW'(d)) && (hseg_i[d-1] == seg_i)) begin
        prod_d[TAPS-1-d] = $signed(hsmp_i[d-1]) * $signed(w_i[TAPS-1-d]);
      end else begin
        prod_d[TAPS-1-d] = '0;
      end
    end
  end

  // Sum, floor shift, saturate
  always_comb begin
    acc = '0;
    for (int t = 0; t < TAPS; t++) begin
      acc = acc + SumW'(prod_q[t]);
    end
    q    = acc[SumW-1:FracShift];
    fits = (q[QW-1:ValW-1] == {(QW-ValW+1){q[ValW-1]}});
    out_d.out_channel = s2_ch_q;
    out_d.saturated   = !fits;
    if (fits) begin
      out_d.out_value = q[ValW-1:0];
    end else if (q[QW-1]) begin
      out_d.out_value = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      out_d.out_value = {1'b0, {(ValW-1){1'b1}}};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s2_adv) begin
      prod_q  <= prod_d;
      s2_ch_q <= ch_i;
    end
    if (s2_valid_q && out_adv) begin
      out_q <= out_d;
    end
  end

  // Advance stage flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s2_adv) begin
        s2_valid_q <= in_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s2_valid_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> design/segmented_causal_depthwise_conv_unit.sv
// ----------------------------------------------------------------------------
// segmented_causal_depthwise_conv_unit
// Per-channel causal FIR with segment-aware history, memory based.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) carries commands:
// weight write, sample, or history clear. Output channel (out_valid_o /
// out_stall_i / out_data_o) carries one filtered item per sample.
// An item is taken at an edge with valid high and stall low.
// Throughput: one item per cycle, any mix of commands and channels, while
// the input is not stalled. The history memory is read when a sample is
// taken and written back when it leaves the first stage; a sample on the
// same channel taken in that cycle is served from the forwarding register,
// so no bubble is needed. The result of a sample passes the memory read,
// the product stage and the sum and saturate into the output register.
// Weight writes and clears finish at the edge they are taken.
// Reset: all weights read as zero and every channel has no past rows; no
// clearing pass is run, the block takes items right after reset.
// A stall on the output holds the result and fills the two stages behind
// it; the input stalls only when those are full.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_causal_depthwise_conv_unit
  import scdconv_pkg::*;
#(
  parameter int unsigned CHANNELS = ChannelsDef,
  parameter int unsigned TAPS     = TapsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned LaneW = $clog2(TAPS);
  localparam int unsigned Hist  = TAPS - 1;
  localparam int unsigned FillW = $clog2(TAPS);

  logic                    accept;
  logic                    ch_ok;
  logic                    tap_ok;
  logic                    w_wr;
  logic                    smp_acc;
  logic                    clr;
  logic [AddrW-1:0]        in_addr;

  logic                    s1_valid_q;
  logic                    s1_valid_d;
  logic [ChW-1:0]          s1_ch_q;
  logic [ValW-1:0]         s1_val_q;
  logic [SegW-1:0]         s1_seg_q;
  logic                    mac_ready;
  logic                    s1_wr;

  logic [TAPS-1:0][ValW-1:0] w_row;
  logic [FillW-1:0]          h_fill;
  logic [Hist-1:0][SegW-1:0] h_seg;
  logic [Hist-1:0][ValW-1:0] h_smp;

  assign in_stall_o = s1_valid_q && !mac_ready;
  assign accept     = in_valid_i && !in_stall_o;
  assign ch_ok      = 32'(in_data_i.channel) < CHANNELS;
  assign tap_ok     = 32'(in_data_i.tap) < TAPS;
  assign in_addr    = AddrW'(in_data_i.channel);

  // Decode the command of the accepted item
  always_comb begin
    w_wr    = 1'b0;
    smp_acc = 1'b0;
    clr     = 1'b0;
    unique case (in_data_i.op)
      OP_WEIGHT: w_wr    = accept && ch_ok && tap_ok;
      OP_SAMPLE: smp_acc = accept && ch_ok;
      OP_CLEAR:  clr     = accept;
      default:   ;
    endcase
  end

  // First stage holds the sample while its memory rows arrive
  assign s1_wr = s1_valid_q && mac_ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!s1_valid_q || mac_ready) begin
      s1_valid_d = smp_acc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (smp_acc) begin
      s1_ch_q  <= in_data_i.channel;
      s1_val_q <= in_data_i.value;
      s1_seg_q <= in_data_i.segment;
    end
  end

  scdconv_wmem #(
    .CHANNELS (CHANNELS),
    .TAPS     (TAPS)
  ) u_wmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (w_wr),
    .wr_ch_i   (in_addr),
    .wr_tap_i  (LaneW'(in_data_i.tap)),
    .wr_data_i (in_data_i.value),
    .rd_en_i   (smp_acc),
    .rd_ch_i   (in_addr),
    .rd_row_o  (w_row)
  );

  scdconv_hist #(
    .CHANNELS (CHANNELS),
    .TAPS     (TAPS)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (clr),
    .rd_en_i  (smp_acc),
    .rd_ch_i  (in_addr),
    .wr_en_i  (s1_wr),
    .wr_ch_i  (AddrW'(s1_ch_q)),
    .wr_smp_i (s1_val_q),
    .wr_seg_i (s1_seg_q),
    .fill_o   (h_fill),
    .seg_o    (h_seg),
    .smp_o    (h_smp)
  );

  scdconv_mac #(
    .TAPS (TAPS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (mac_ready),
    .ch_i        (s1_ch_q),
    .val_i       (s1_val_q),
    .seg_i       (s1_seg_q),
    .w_i         (w_row),
    .fill_i      (h_fill),
    .hseg_i      (h_seg),
    .hsmp_i      (h_smp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
